[design/esc_pkg.sv]
// Shared types, codes and floor-scan helpers for the elevator scan controller.
package esc_pkg;

	localparam int FLOORS = 4;
	localparam int FLR_W  = 3;
	localparam int MASK_W = FLOORS;
	localparam int DUTY_W = 7;
	localparam int TIME_W = 32;
	localparam int IVL_W  = 16;
	localparam int CFG_AW = 3;

	localparam logic [CFG_AW-1:0] CFG_DUTY_FULL  = 3'd0;
	localparam logic [CFG_AW-1:0] CFG_DUTY_SLOW  = 3'd1;
	localparam logic [CFG_AW-1:0] CFG_DUTY_STOP  = 3'd2;
	localparam logic [CFG_AW-1:0] CFG_RAMP_STEP  = 3'd3;
	localparam logic [CFG_AW-1:0] CFG_RAMP_IVL   = 3'd4;

	// Reported state codes.
	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_DISPATCH = 4'd1;
	localparam logic [3:0] ST_UP       = 4'd2;
	localparam logic [3:0] ST_DOWN     = 4'd3;
	localparam logic [3:0] ST_DECEL    = 4'd4;
	localparam logic [3:0] ST_OPEN     = 4'd5;
	localparam logic [3:0] ST_CLOSING  = 4'd6;
	localparam logic [3:0] ST_EMERG    = 4'd7;
	localparam logic [3:0] ST_INDEP    = 4'd8;

	localparam logic [2:0] PKT_IDLE    = 3'd0;
	localparam logic [2:0] PKT_UP      = 3'd1;
	localparam logic [2:0] PKT_DOWN    = 3'd2;
	localparam logic [2:0] PKT_OPEN    = 3'd3;
	localparam logic [2:0] PKT_CLOSING = 3'd4;
	localparam logic [2:0] PKT_EMERG   = 3'd5;

	typedef enum logic [3:0] {
		OP_RUN       = 4'd0,
		OP_CABIN     = 4'd1,
		OP_HALL      = 4'd2,
		OP_SENSOR    = 4'd3,
		OP_ESTOP     = 4'd4,
		OP_ECLEAR    = 4'd5,
		OP_DOOR_DONE = 4'd6,
		OP_INDEP_ON  = 4'd7,
		OP_INDEP_OFF = 4'd8,
		OP_NOP       = 4'd9
	} op_t;

	typedef enum logic [1:0] {
		DIR_IDLE = 2'd0,
		DIR_UP   = 2'd1,
		DIR_DN   = 2'd2
	} dir_t;

	typedef enum logic [8:0] {
		MODE_IDLE     = 9'b000000001,
		MODE_DISPATCH = 9'b000000010,
		MODE_UP       = 9'b000000100,
		MODE_DOWN     = 9'b000001000,
		MODE_DECEL    = 9'b000010000,
		MODE_OPEN     = 9'b000100000,
		MODE_CLOSING  = 9'b001000000,
		MODE_EMERG    = 9'b010000000,
		MODE_INDEP    = 9'b100000000
	} mode_t;

	// Classified event as it travels from the front end to the back end.
	typedef struct packed {
		op_t                op;
		logic               floor_ok;
		logic [FLR_W-1:0]   floor;
		logic [MASK_W-1:0]  mask;
		logic [TIME_W-1:0]  time_ms;
	} cmd_t;

	// Result snapshot, packed so that the last field lands in the lowest bits.
	typedef struct packed {
		logic [3:0]         pad;
		logic               start_door_timer;
		logic [DUTY_W-1:0]  motor_duty;
		logic               door_flag;
		logic [MASK_W-1:0]  pending_mask;
		logic [1:0]         travel_dir;
		logic [FLR_W-1:0]   goal_floor;
		logic [FLR_W-1:0]   car_floor;
		logic [2:0]         packet_state;
		logic [3:0]         fsm_state;
	} result_t;

	function automatic logic [MASK_W-1:0] fbit(input logic [FLR_W-1:0] f);
		logic [MASK_W-1:0] m;
		m = '0;
		for (int i = 0; i < FLOORS; i++) begin
			if (f == FLR_W'(i + 1)) m[i] = 1'b1;
		end
		return m;
	endfunction

	function automatic logic [FLR_W-1:0] lowest_floor(input logic [MASK_W-1:0] p);
		logic [FLR_W-1:0] r;
		r = '0;
		for (int i = FLOORS - 1; i >= 0; i--) begin
			if (p[i]) r = FLR_W'(i + 1);
		end
		return r;
	endfunction

	// Nearest requested floor above the car.
	function automatic logic [FLR_W-1:0] scan_up(input logic [FLR_W-1:0] at,
			input logic [MASK_W-1:0] p);
		logic [FLR_W-1:0] r;
		r = '0;
		for (int i = FLOORS - 1; i >= 0; i--) begin
			if (p[i] && (i + 1) > int'(at)) r = FLR_W'(i + 1);
		end
		return r;
	endfunction

	// Nearest requested floor below the car.
	function automatic logic [FLR_W-1:0] scan_down(input logic [FLR_W-1:0] at,
			input logic [MASK_W-1:0] p);
		logic [FLR_W-1:0] r;
		r = '0;
		for (int i = 0; i < FLOORS; i++) begin
			if (p[i] && (i + 1) < int'(at)) r = FLR_W'(i + 1);
		end
		return r;
	endfunction

	function automatic logic [FLR_W-1:0] pick_target(input logic [FLR_W-1:0] at,
			input dir_t dir, input logic [MASK_W-1:0] p);
		logic [FLR_W-1:0] u;
		logic [FLR_W-1:0] d;
		logic [FLR_W-1:0] r;
		u = scan_up(at, p);
		d = scan_down(at, p);
		if (dir == DIR_DN) begin
			r = (d != '0) ? d : ((u != '0) ? u : lowest_floor(p));
		end else begin
			r = (u != '0) ? u : ((d != '0) ? d : lowest_floor(p));
		end
		return r;
	endfunction

	// En-route pickup: a nearer request strictly between the car and the target.
	function automatic logic [FLR_W-1:0] reeval_up(input logic [FLR_W-1:0] at,
			input logic [FLR_W-1:0] tgt, input logic [MASK_W-1:0] p);
		logic [FLR_W-1:0] r;
		r = tgt;
		for (int i = FLOORS - 1; i >= 0; i--) begin
			if (p[i] && (i + 1) > int'(at) && (i + 1) < int'(tgt)) r = FLR_W'(i + 1);
		end
		return r;
	endfunction

	function automatic logic [FLR_W-1:0] reeval_down(input logic [FLR_W-1:0] at,
			input logic [FLR_W-1:0] tgt, input logic [MASK_W-1:0] p);
		logic [FLR_W-1:0] r;
		r = tgt;
		for (int i = 0; i < FLOORS; i++) begin
			if (p[i] && (i + 1) < int'(at) && (i + 1) > int'(tgt)) r = FLR_W'(i + 1);
		end
		return r;
	endfunction

	function automatic logic [3:0] mode_code(input mode_t m);
		logic [3:0] c;
		unique case (m)
			MODE_IDLE:     c = ST_IDLE;
			MODE_DISPATCH: c = ST_DISPATCH;
			MODE_UP:       c = ST_UP;
			MODE_DOWN:     c = ST_DOWN;
			MODE_DECEL:    c = ST_DECEL;
			MODE_OPEN:     c = ST_OPEN;
			MODE_CLOSING:  c = ST_CLOSING;
			MODE_EMERG:    c = ST_EMERG;
			MODE_INDEP:    c = ST_INDEP;
			default:       c = ST_IDLE;
		endcase
		return c;
	endfunction

	function automatic logic [2:0] packet_code(input mode_t m, input dir_t dir);
		logic [2:0] c;
		unique case (m)
			MODE_UP:       c = PKT_UP;
			MODE_DOWN:     c = PKT_DOWN;
			MODE_DECEL:    c = (dir == DIR_UP) ? PKT_UP : PKT_DOWN;
			MODE_OPEN:     c = PKT_OPEN;
			MODE_CLOSING:  c = PKT_CLOSING;
			MODE_EMERG:    c = PKT_EMERG;
			MODE_INDEP:    c = PKT_EMERG;
			default:       c = PKT_IDLE;
		endcase
		return c;
	endfunction

endpackage

[design/esc_front.sv]
// Front end: takes events from the input stream and classifies them for the queue.
module esc_front (
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [39:0]          s_axis_tdata,  // floor[2:0], call_mask[6:3], time_ms[38:7], zero
	input  logic [3:0]           s_axis_tuser,  // action[3:0]
	input  logic                 queue_full,
	output logic                 push,
	output esc_pkg::cmd_t        cmd
);

	logic [esc_pkg::FLR_W-1:0] floor;

	assign floor         = s_axis_tdata[2:0];
	assign s_axis_tready = !queue_full;
	assign push          = s_axis_tvalid && !queue_full;

	always_comb begin
		cmd.floor    = floor;
		cmd.floor_ok = (esc_pkg::fbit(floor) != '0);
		cmd.mask     = s_axis_tdata[6:3];
		cmd.time_ms  = s_axis_tdata[38:7];
		// Codes beyond the defined actions collapse into a no-operation.
		unique case (s_axis_tuser)
			esc_pkg::OP_RUN:       cmd.op = esc_pkg::OP_RUN;
			esc_pkg::OP_CABIN:     cmd.op = esc_pkg::OP_CABIN;
			esc_pkg::OP_HALL:      cmd.op = esc_pkg::OP_HALL;
			esc_pkg::OP_SENSOR:    cmd.op = esc_pkg::OP_SENSOR;
			esc_pkg::OP_ESTOP:     cmd.op = esc_pkg::OP_ESTOP;
			esc_pkg::OP_ECLEAR:    cmd.op = esc_pkg::OP_ECLEAR;
			esc_pkg::OP_DOOR_DONE: cmd.op = esc_pkg::OP_DOOR_DONE;
			esc_pkg::OP_INDEP_ON:  cmd.op = esc_pkg::OP_INDEP_ON;
			esc_pkg::OP_INDEP_OFF: cmd.op = esc_pkg::OP_INDEP_OFF;
			default:               cmd.op = esc_pkg::OP_NOP;
		endcase
	end

endmodule

[design/esc_queue.sv]
// Short command queue between the front end and the back end.
module esc_queue #(
	parameter int DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  esc_pkg::cmd_t  push_cmd,
	output logic           full,
	input  logic           pop,
	output logic           valid,
	output esc_pkg::cmd_t  head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	esc_pkg::cmd_t    mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign valid = (count_q != '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[design/esc_back.sv]
// Back end: controller state, duty ramp, SCAN dispatch and the result register.
module esc_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_addr,
	input  logic [15:0]          cfg_wdata,
	input  logic                 cmd_valid,
	input  esc_pkg::cmd_t        cmd,
	output logic                 pop,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [31:0]          m_axis_tdata
);

	localparam int FW = esc_pkg::FLR_W;
	localparam int MW = esc_pkg::MASK_W;
	localparam int DW = esc_pkg::DUTY_W;
	localparam int TW = esc_pkg::TIME_W;

	// Configuration registers.
	logic [DW-1:0]             duty_full_q, duty_slow_q, duty_stop_q, ramp_step_q;
	logic [esc_pkg::IVL_W-1:0] ramp_ivl_q;

	// Controller state.
	esc_pkg::mode_t mode_q;
	esc_pkg::dir_t  dir_q;
	logic [FW-1:0]  at_q, tgt_q, sfloor_q;
	logic [MW-1:0]  cab_q, hall_q;
	logic           emg_q, door_q, trun_q, spend_q;
	logic [DW-1:0]  dnow_q, dgoal_q;
	logic [TW-1:0]  lrt_q;

	logic             out_valid_q;
	esc_pkg::result_t res_q;

	// Next-state values.
	esc_pkg::mode_t mode_d;
	esc_pkg::dir_t  dir_d;
	logic [FW-1:0]  at_d, tgt_d, sfloor_d;
	logic [MW-1:0]  cab_d, hall_d;
	logic           emg_d, door_d, trun_d, spend_d, pulse_d;
	logic [DW-1:0]  dnow_d, dgoal_d;
	logic [TW-1:0]  lrt_d;
	esc_pkg::result_t res_d;

	assign pop           = cmd_valid && (!out_valid_q || m_axis_tready);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = res_q;

	always_comb begin
		logic [MW-1:0] p;
		logic [FW-1:0] t;
		logic [DW-1:0] rem;
		logic          do_open;
		logic          up;

		mode_d   = mode_q;
		dir_d    = dir_q;
		at_d     = at_q;
		tgt_d    = tgt_q;
		sfloor_d = sfloor_q;
		cab_d    = cab_q;
		hall_d   = hall_q;
		emg_d    = emg_q;
		door_d   = door_q;
		trun_d   = trun_q;
		spend_d  = spend_q;
		dnow_d   = dnow_q;
		dgoal_d  = dgoal_q;
		lrt_d    = lrt_q;
		pulse_d  = 1'b0;
		do_open  = 1'b0;
		up       = (mode_q == esc_pkg::MODE_UP);
		p        = cab_q | hall_q;
		t        = '0;
		rem      = '0;

		unique case (cmd.op)
			esc_pkg::OP_RUN: begin
				// Ramp first, using the duty goal left by the previous step.
				if (dnow_q != dgoal_q &&
						(cmd.time_ms - lrt_q) >= TW'(ramp_ivl_q)) begin
					lrt_d = cmd.time_ms;
					if (dnow_q < dgoal_q) begin
						rem    = dgoal_q - dnow_q;
						dnow_d = (rem <= ramp_step_q) ? dgoal_q : dnow_q + ramp_step_q;
					end else begin
						rem    = dnow_q - dgoal_q;
						dnow_d = (rem <= ramp_step_q) ? dgoal_q : dnow_q - ramp_step_q;
					end
				end
				if (emg_q) begin
					mode_d  = esc_pkg::MODE_EMERG;
					dgoal_d = duty_stop_q;
					dnow_d  = duty_stop_q;
				end else begin
					unique case (mode_q)
						esc_pkg::MODE_IDLE: begin
							dgoal_d = duty_stop_q;
							dir_d   = esc_pkg::DIR_IDLE;
							tgt_d   = '0;
							if ((p & esc_pkg::fbit(at_q)) != '0) begin
								do_open = 1'b1;
							end else if (p != '0) begin
								mode_d = esc_pkg::MODE_DISPATCH;
							end
						end
						esc_pkg::MODE_DISPATCH: begin
							t = esc_pkg::pick_target(at_q, dir_q, p);
							if (p == '0) begin
								mode_d = esc_pkg::MODE_IDLE;
							end else begin
								tgt_d = t;
								if (t > at_q) begin
									dir_d  = esc_pkg::DIR_UP;
									mode_d = esc_pkg::MODE_UP;
								end else if (t < at_q) begin
									dir_d  = esc_pkg::DIR_DN;
									mode_d = esc_pkg::MODE_DOWN;
								end else begin
									do_open = 1'b1;
								end
								dgoal_d = duty_full_q;
							end
						end
						esc_pkg::MODE_UP, esc_pkg::MODE_DOWN: begin
							dgoal_d = duty_full_q;
							// A sensor report counts only as a one-floor move
							// that agrees with the direction of travel.
							if (spend_q) begin
								spend_d = 1'b0;
								if ({1'b0, sfloor_q} == {1'b0, at_q} + 1'b1) begin
									if (dir_q != esc_pkg::DIR_DN) at_d = sfloor_q;
								end else if ({1'b0, sfloor_q} + 1'b1 == {1'b0, at_q}) begin
									if (dir_q != esc_pkg::DIR_UP) at_d = sfloor_q;
								end
							end
							if (dir_q == esc_pkg::DIR_UP) begin
								tgt_d = esc_pkg::reeval_up(at_d, tgt_q, p);
							end else if (dir_q == esc_pkg::DIR_DN) begin
								tgt_d = esc_pkg::reeval_down(at_d, tgt_q, p);
							end
							if (at_d == tgt_d || (p & esc_pkg::fbit(at_d)) != '0 ||
									(up ? (at_d >= FW'(esc_pkg::FLOORS)) : (at_d <= FW'(1)))) begin
								mode_d  = esc_pkg::MODE_DECEL;
								dgoal_d = duty_slow_q;
							end
						end
						esc_pkg::MODE_DECEL: begin
							dgoal_d = duty_slow_q;
							if (dnow_d <= duty_slow_q) do_open = 1'b1;
						end
						esc_pkg::MODE_OPEN: begin
							dgoal_d = duty_stop_q;
							if (!trun_q) mode_d = esc_pkg::MODE_CLOSING;
						end
						esc_pkg::MODE_CLOSING: begin
							door_d  = 1'b0;
							dgoal_d = duty_stop_q;
							if (p != '0) begin
								mode_d = esc_pkg::MODE_DISPATCH;
							end else begin
								mode_d = esc_pkg::MODE_IDLE;
								dir_d  = esc_pkg::DIR_IDLE;
								tgt_d  = '0;
							end
						end
						esc_pkg::MODE_EMERG: begin
							dgoal_d = duty_stop_q;
							dnow_d  = duty_stop_q;
						end
						esc_pkg::MODE_INDEP: begin
							if (cab_q != '0) mode_d = esc_pkg::MODE_IDLE;
						end
						default: begin
							mode_d = esc_pkg::MODE_IDLE;
						end
					endcase
					if (do_open) begin
						cab_d  = cab_q & ~esc_pkg::fbit(at_q);
						hall_d = hall_q & ~esc_pkg::fbit(at_q);
						door_d = 1'b1;
						mode_d = esc_pkg::MODE_OPEN;
						if (!trun_q) begin
							trun_d  = 1'b1;
							pulse_d = 1'b1;
						end
					end
				end
			end
			esc_pkg::OP_CABIN: begin
				cab_d = cab_q | esc_pkg::fbit(cmd.floor);
			end
			esc_pkg::OP_HALL: begin
				hall_d = hall_q | cmd.mask;
			end
			esc_pkg::OP_SENSOR: begin
				if (cmd.floor_ok) begin
					sfloor_d = cmd.floor;
					spend_d  = 1'b1;
				end
			end
			esc_pkg::OP_ESTOP: begin
				emg_d   = 1'b1;
				mode_d  = esc_pkg::MODE_EMERG;
				dgoal_d = duty_stop_q;
				dnow_d  = duty_stop_q;
			end
			esc_pkg::OP_ECLEAR: begin
				emg_d  = 1'b0;
				mode_d = esc_pkg::MODE_IDLE;
				dir_d  = esc_pkg::DIR_IDLE;
				tgt_d  = '0;
			end
			esc_pkg::OP_DOOR_DONE: begin
				trun_d = 1'b0;
			end
			esc_pkg::OP_INDEP_ON: begin
				hall_d  = '0;
				tgt_d   = '0;
				dgoal_d = duty_stop_q;
				dnow_d  = duty_stop_q;
				mode_d  = esc_pkg::MODE_INDEP;
				dir_d   = esc_pkg::DIR_IDLE;
				door_d  = 1'b0;
			end
			esc_pkg::OP_INDEP_OFF: begin
				if (mode_q == esc_pkg::MODE_INDEP) begin
					mode_d = esc_pkg::MODE_IDLE;
					dir_d  = esc_pkg::DIR_IDLE;
					tgt_d  = '0;
				end
			end
			default: begin
			end
		endcase

		res_d.pad              = '0;
		res_d.fsm_state        = esc_pkg::mode_code(mode_d);
		res_d.packet_state     = esc_pkg::packet_code(mode_d, dir_d);
		res_d.car_floor        = at_d;
		res_d.goal_floor       = tgt_d;
		res_d.travel_dir       = dir_d;
		res_d.pending_mask     = (mode_d == esc_pkg::MODE_INDEP) ? cab_d : (cab_d | hall_d);
		res_d.door_flag        = door_d;
		res_d.motor_duty       = dnow_d;
		res_d.start_door_timer = pulse_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_full_q <= DW'(100);
			duty_slow_q <= DW'(30);
			duty_stop_q <= '0;
			ramp_step_q <= DW'(10);
			ramp_ivl_q  <= esc_pkg::IVL_W'(50);
		end else if (cfg_we) begin
			unique case (cfg_addr)
				esc_pkg::CFG_DUTY_FULL: duty_full_q <= cfg_wdata[DW-1:0];
				esc_pkg::CFG_DUTY_SLOW: duty_slow_q <= cfg_wdata[DW-1:0];
				esc_pkg::CFG_DUTY_STOP: duty_stop_q <= cfg_wdata[DW-1:0];
				esc_pkg::CFG_RAMP_STEP: ramp_step_q <= cfg_wdata[DW-1:0];
				esc_pkg::CFG_RAMP_IVL:  ramp_ivl_q  <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= esc_pkg::MODE_IDLE;
			dir_q    <= esc_pkg::DIR_IDLE;
			at_q     <= FW'(1);
			tgt_q    <= '0;
			sfloor_q <= '0;
			cab_q    <= '0;
			hall_q   <= '0;
			emg_q    <= 1'b0;
			door_q   <= 1'b0;
			trun_q   <= 1'b0;
			spend_q  <= 1'b0;
			dnow_q   <= '0;
			dgoal_q  <= '0;
			lrt_q    <= '0;
		end else if (pop) begin
			mode_q   <= mode_d;
			dir_q    <= dir_d;
			at_q     <= at_d;
			tgt_q    <= tgt_d;
			sfloor_q <= sfloor_d;
			cab_q    <= cab_d;
			hall_q   <= hall_d;
			emg_q    <= emg_d;
			door_q   <= door_d;
			trun_q   <= trun_d;
			spend_q  <= spend_d;
			dnow_q   <= dnow_d;
			dgoal_q  <= dgoal_d;
			lrt_q    <= lrt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res_d;
		end
	end

	a_mode_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(mode_q))
		else $error("controller mode register is not one-hot");

	a_floor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(at_q >= FW'(1) && at_q <= FW'(esc_pkg::FLOORS)))
		else $error("car floor left the valid range");

	a_pulse_doors: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.start_door_timer |->
			res_q.door_flag && res_q.fsm_state == esc_pkg::ST_OPEN)
		else $error("door timer started without doors open");

	a_emerg_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pop && cmd.op == esc_pkg::OP_RUN && emg_q |=>
			mode_q == esc_pkg::MODE_EMERG && dnow_q == duty_stop_q)
		else $error("run step under emergency did not hold the car");

endmodule

[design/elevator_scan_controller.sv]
// Elevator scan controller top level: one event in, one status snapshot out per event.
// The front end accepts one event per cycle into a QUEUE_DEPTH-entry queue and the back end
// retires one event per cycle through a combinational state update into an output register,
// so the sustained rate is one event per clock while the output is ready. A result is
// registered when the back end takes its event from the queue and is held until it transfers;
// while the output stalls the queue fills and then holds the input off.
// Configuration writes apply to every event that the back end retires after the write.
module elevator_scan_controller #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [15:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // floor[2:0], call_mask[6:3], time_ms[38:7], zero[39]
	input  logic [3:0]  s_axis_tuser,  // action[3:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// fsm_state[3:0], packet_state[6:4], car_floor[9:7], goal_floor[12:10],
	// travel_dir[14:13], pending_mask[18:15], door flag[19], motor_duty[26:20],
	// start_door_timer[27], zero[31:28]
	output logic [31:0] m_axis_tdata
);

	logic          push, full, pop, q_valid;
	esc_pkg::cmd_t push_cmd, head_cmd;

	esc_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.queue_full    (full),
		.push          (push),
		.cmd           (push_cmd)
	);

	esc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full),
		.pop      (pop),
		.valid    (q_valid),
		.head     (head_cmd)
	);

	esc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.cmd_valid     (q_valid),
		.cmd           (head_cmd),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

[verif/elevator_scan_controller_tb.sv]
// Self-checking testbench for the elevator scan controller: directed and random events.
`timescale 1ns / 1ps

module elevator_scan_controller_tb;

	localparam int WATCHDOG_LIMIT = 5000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_addr = '0;
	logic [15:0] cfg_wdata = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;  // floor[2:0], call_mask[6:3], time_ms[38:7], zero[39]
	logic [3:0]  s_axis_tuser = '0;  // action[3:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// fsm_state[3:0], packet_state[6:4], car_floor[9:7], goal_floor[12:10],
	// travel_dir[14:13], pending_mask[18:15], door flag[19], motor_duty[26:20],
	// start_door_timer[27], zero[31:28]
	logic [31:0] m_axis_tdata;

	// Handshake pacing, in percent of cycles.
	int src_gap_pct = 6;
	int stall_pct = 83;
	int err_count = 0;
	int quiet_cycles = 0;
	logic [31:0] clock_ms = '0;

	esc_pkg::result_t expected_status[$];

	// Register copies as the controller should hold them.
	int cfg_full = 100;
	int cfg_slow = 30;
	int cfg_stop = 0;
	int cfg_step = 10;
	int cfg_ivl = 50;

	// Car state as the controller should hold it.
	logic [3:0]    car_mode = esc_pkg::ST_IDLE;
	int            car_at = 1;
	int            goal = 0;
	esc_pkg::dir_t heading = esc_pkg::DIR_IDLE;
	logic [3:0]    cabin_reqs = '0;
	logic [3:0]    hall_reqs = '0;
	bit            estop_on = 1'b0;
	bit            door_held = 1'b0;
	bit            door_timer_on = 1'b0;
	bit            sensor_waiting = 1'b0;
	int            sensor_at = 0;
	int            duty_cur = 0;
	int            duty_aim = 0;
	logic [31:0]   last_ramp = '0;
	bit            timer_kick = 1'b0;

	elevator_scan_controller dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #10 clk = ~clk;

	function automatic logic [3:0] level_bit(input int f);
		return (f >= 1 && f <= esc_pkg::FLOORS) ? 4'(1 << (f - 1)) : 4'b0000;
	endfunction

	// In independent mode only cabin requests are served.
	function automatic logic [3:0] waiting_floors();
		return (car_mode == esc_pkg::ST_INDEP) ? cabin_reqs : (cabin_reqs | hall_reqs);
	endfunction

	// Nearest requested floor walking from the car in the given direction, 0 if none.
	function automatic int nearest_call(input logic [3:0] p, input int dir_step);
		for (int f = car_at + dir_step; f >= 1 && f <= esc_pkg::FLOORS; f += dir_step) begin
			if ((p & level_bit(f)) != 0) return f;
		end
		return 0;
	endfunction

	function automatic void open_doors();
		cabin_reqs &= ~level_bit(car_at);
		hall_reqs &= ~level_bit(car_at);
		door_held = 1'b1;
		car_mode = esc_pkg::ST_OPEN;
		if (!door_timer_on) begin
			door_timer_on = 1'b1;
			timer_kick = 1'b1;
		end
	endfunction

	function automatic void travel(input bit going_up);
		logic [3:0] p;
		duty_aim = cfg_full;
		// A sensor report only counts as a one-floor move that agrees with the heading.
		if (sensor_waiting) begin
			sensor_waiting = 1'b0;
			if ((sensor_at == car_at + 1 && heading != esc_pkg::DIR_DN) ||
					(sensor_at + 1 == car_at && heading != esc_pkg::DIR_UP))
				car_at = sensor_at;
		end
		p = waiting_floors();
		// Pick up a request strictly between the car and the goal; the loop bound
		// stops the search once the goal moves in.
		if (p != 0) begin
			if (heading == esc_pkg::DIR_UP) begin
				for (int f = car_at + 1; f < goal; f++)
					if ((p & level_bit(f)) != 0) goal = f;
			end else if (heading == esc_pkg::DIR_DN) begin
				for (int f = car_at - 1; f > goal; f--)
					if ((p & level_bit(f)) != 0) goal = f;
			end
		end
		if (car_at == goal || (waiting_floors() & level_bit(car_at)) != 0 ||
				(going_up ? car_at >= esc_pkg::FLOORS : car_at <= 1)) begin
			car_mode = esc_pkg::ST_DECEL;
			duty_aim = cfg_slow;
		end
	endfunction

	function automatic esc_pkg::result_t apply_event(input logic [3:0] act,
			input logic [2:0] fl, input logic [3:0] mk, input logic [31:0] tm);
		esc_pkg::result_t r;
		logic [31:0]      elapsed;
		logic [3:0]       p;
		int               pick;
		int               up_hit;
		int               dn_hit;
		timer_kick = 1'b0;
		unique case (act)
			esc_pkg::OP_RUN: begin
				elapsed = tm - last_ramp;
				if (duty_cur != duty_aim && elapsed >= 32'(cfg_ivl)) begin
					last_ramp = tm;
					if (duty_cur < duty_aim)
						duty_cur = (duty_aim - duty_cur <= cfg_step) ? duty_aim
							: duty_cur + cfg_step;
					else
						duty_cur = (duty_cur - duty_aim <= cfg_step) ? duty_aim
							: duty_cur - cfg_step;
				end
				if (estop_on) begin
					car_mode = esc_pkg::ST_EMERG;
					duty_aim = cfg_stop;
					duty_cur = cfg_stop;
				end else begin
					unique case (car_mode)
						esc_pkg::ST_IDLE: begin
							duty_aim = cfg_stop;
							heading = esc_pkg::DIR_IDLE;
							goal = 0;
							if ((waiting_floors() & level_bit(car_at)) != 0) open_doors();
							else if (waiting_floors() != 0) car_mode = esc_pkg::ST_DISPATCH;
						end
						esc_pkg::ST_DISPATCH: begin
							p = waiting_floors();
							pick = 0;
							if (p != 0) begin
								up_hit = nearest_call(p, 1);
								dn_hit = nearest_call(p, -1);
								if (heading == esc_pkg::DIR_DN)
									pick = (dn_hit != 0) ? dn_hit : up_hit;
								else
									pick = (up_hit != 0) ? up_hit : dn_hit;
								// Nothing above or below: the only request is here.
								if (pick == 0) pick = car_at;
							end
							if (pick == 0) begin
								car_mode = esc_pkg::ST_IDLE;
							end else begin
								goal = pick;
								if (pick > car_at) begin
									heading = esc_pkg::DIR_UP;
									car_mode = esc_pkg::ST_UP;
								end else if (pick < car_at) begin
									heading = esc_pkg::DIR_DN;
									car_mode = esc_pkg::ST_DOWN;
								end else begin
									open_doors();
								end
								duty_aim = cfg_full;
							end
						end
						esc_pkg::ST_UP: travel(1'b1);
						esc_pkg::ST_DOWN: travel(1'b0);
						esc_pkg::ST_DECEL: begin
							duty_aim = cfg_slow;
							if (duty_cur <= cfg_slow) open_doors();
						end
						esc_pkg::ST_OPEN: begin
							duty_aim = cfg_stop;
							if (!door_timer_on) car_mode = esc_pkg::ST_CLOSING;
						end
						esc_pkg::ST_CLOSING: begin
							door_held = 1'b0;
							duty_aim = cfg_stop;
							if (waiting_floors() != 0) begin
								car_mode = esc_pkg::ST_DISPATCH;
							end else begin
								car_mode = esc_pkg::ST_IDLE;
								heading = esc_pkg::DIR_IDLE;
								goal = 0;
							end
						end
						esc_pkg::ST_EMERG: begin
							duty_aim = cfg_stop;
							duty_cur = cfg_stop;
						end
						esc_pkg::ST_INDEP: begin
							if (cabin_reqs != 0) car_mode = esc_pkg::ST_IDLE;
						end
						default: car_mode = esc_pkg::ST_IDLE;
					endcase
				end
			end
			esc_pkg::OP_CABIN: cabin_reqs |= level_bit(fl);
			esc_pkg::OP_HALL: hall_reqs |= mk;
			esc_pkg::OP_SENSOR: begin
				if (level_bit(fl) != 0) begin
					sensor_at = fl;
					sensor_waiting = 1'b1;
				end
			end
			esc_pkg::OP_ESTOP: begin
				estop_on = 1'b1;
				car_mode = esc_pkg::ST_EMERG;
				duty_aim = cfg_stop;
				duty_cur = cfg_stop;
			end
			esc_pkg::OP_ECLEAR: begin
				estop_on = 1'b0;
				car_mode = esc_pkg::ST_IDLE;
				heading = esc_pkg::DIR_IDLE;
				goal = 0;
			end
			esc_pkg::OP_DOOR_DONE: door_timer_on = 1'b0;
			esc_pkg::OP_INDEP_ON: begin
				hall_reqs = '0;
				goal = 0;
				duty_aim = cfg_stop;
				duty_cur = cfg_stop;
				car_mode = esc_pkg::ST_INDEP;
				heading = esc_pkg::DIR_IDLE;
				door_held = 1'b0;
			end
			esc_pkg::OP_INDEP_OFF: begin
				if (car_mode == esc_pkg::ST_INDEP) begin
					car_mode = esc_pkg::ST_IDLE;
					heading = esc_pkg::DIR_IDLE;
					goal = 0;
				end
			end
			default: ;
		endcase

		r = '0;
		r.fsm_state = car_mode;
		unique case (car_mode)
			esc_pkg::ST_UP:      r.packet_state = esc_pkg::PKT_UP;
			esc_pkg::ST_DOWN:    r.packet_state = esc_pkg::PKT_DOWN;
			esc_pkg::ST_DECEL:   r.packet_state = (heading == esc_pkg::DIR_UP) ?
				esc_pkg::PKT_UP : esc_pkg::PKT_DOWN;
			esc_pkg::ST_OPEN:    r.packet_state = esc_pkg::PKT_OPEN;
			esc_pkg::ST_CLOSING: r.packet_state = esc_pkg::PKT_CLOSING;
			esc_pkg::ST_EMERG:   r.packet_state = esc_pkg::PKT_EMERG;
			esc_pkg::ST_INDEP:   r.packet_state = esc_pkg::PKT_EMERG;
			default:             r.packet_state = esc_pkg::PKT_IDLE;
		endcase
		r.car_floor = 3'(car_at);
		r.goal_floor = 3'(goal);
		r.travel_dir = heading;
		r.pending_mask = waiting_floors();
		r.door_flag = door_held;
		r.motor_duty = 7'(duty_cur);
		r.start_door_timer = timer_kick;
		return r;
	endfunction

	function automatic void check_field(input string label, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
			err_count++;
		end
	endfunction

	// Offers one event and records the status it should produce once it is taken.
	task automatic send_event(input logic [3:0] act, input logic [2:0] fl,
			input logic [3:0] mk, input logic [31:0] tm);
		while ($urandom_range(99) < src_gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= act;
		s_axis_tdata <= {1'b0, tm, mk, fl};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		expected_status.push_back(apply_event(act, fl, mk, tm));
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (expected_status.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] addr, input logic [15:0] data);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_settings(input int full, input int slow, input int stop,
			input int step, input int ivl);
		drain_results();
		write_reg(esc_pkg::CFG_DUTY_FULL, 16'(full));
		write_reg(esc_pkg::CFG_DUTY_SLOW, 16'(slow));
		write_reg(esc_pkg::CFG_DUTY_STOP, 16'(stop));
		write_reg(esc_pkg::CFG_RAMP_STEP, 16'(step));
		write_reg(esc_pkg::CFG_RAMP_IVL, 16'(ivl));
		cfg_full = full;
		cfg_slow = slow;
		cfg_stop = stop;
		cfg_step = step;
		cfg_ivl = ivl;
	endtask

	// Reset defaults, ignored inputs, opening at the present floor, a stale sensor
	// report, emergency and independent mode.
	task automatic test_directed_events();
		send_event(esc_pkg::OP_RUN, 3'd0, 4'b0000, 32'd0);
		send_event(esc_pkg::OP_NOP, 3'd0, 4'b0000, 32'd0);
		send_event(esc_pkg::OP_INDEP_OFF, 3'd0, 4'b0000, 32'd0);
		send_event(esc_pkg::OP_CABIN, 3'd0, 4'b0000, 32'd0);
		send_event(esc_pkg::OP_SENSOR, 3'd7, 4'b0000, 32'd0);
		send_event(esc_pkg::OP_SENSOR, 3'd2, 4'b0000, 32'd0);
		send_event(esc_pkg::OP_HALL, 3'd0, 4'b0001, 32'd0);
		send_event(esc_pkg::OP_RUN, 3'd0, 4'b0000, 32'd10);
		send_event(esc_pkg::OP_DOOR_DONE, 3'd0, 4'b0000, 32'd0);
		send_event(esc_pkg::OP_CABIN, 3'd1, 4'b0000, 32'd0);
		send_event(esc_pkg::OP_RUN, 3'd0, 4'b0000, 32'd20);
		send_event(esc_pkg::OP_RUN, 3'd0, 4'b0000, 32'd30);
		// The only request is the present floor, so dispatch opens the doors here.
		send_event(esc_pkg::OP_RUN, 3'd0, 4'b0000, 32'd40);
		send_event(esc_pkg::OP_DOOR_DONE, 3'd0, 4'b0000, 32'd0);
		send_event(esc_pkg::OP_HALL, 3'd0, 4'b1111, 32'd0);
		send_event(esc_pkg::OP_RUN, 3'd0, 4'b0000, 32'd100);
		send_event(esc_pkg::OP_RUN, 3'd0, 4'b0000, 32'd160);
		send_event(esc_pkg::OP_RUN, 3'd0, 4'b0000, 32'd220);
		send_event(esc_pkg::OP_RUN, 3'd0, 4'b0000, 32'hFFFF_FFFF);
		send_event(esc_pkg::OP_ESTOP, 3'd0, 4'b0000, 32'd0);
		send_event(esc_pkg::OP_RUN, 3'd0, 4'b0000, 32'd0);
		send_event(esc_pkg::OP_ECLEAR, 3'd0, 4'b0000, 32'd0);
		send_event(esc_pkg::OP_INDEP_ON, 3'd0, 4'b0000, 32'd0);
		send_event(esc_pkg::OP_INDEP_OFF, 3'd0, 4'b0000, 32'd0);
	endtask

	// A zero ramp step freezes the duty, and duty values above 100 are taken as given.
	task automatic test_ramp_corners();
		load_settings(127, 127, 0, 0, 50);
		send_event(esc_pkg::OP_CABIN, 3'd4, 4'b0000, 32'd0);
		send_event(esc_pkg::OP_RUN, 3'd0, 4'b0000, 32'd1000);
		send_event(esc_pkg::OP_RUN, 3'd0, 4'b0000, 32'd2000);
		send_event(esc_pkg::OP_RUN, 3'd0, 4'b0000, 32'd3000);
		send_event(esc_pkg::OP_SENSOR, 3'd3, 4'b0000, 32'd0);
		send_event(esc_pkg::OP_RUN, 3'd0, 4'b0000, 32'd4000);
	endtask

	// Mostly events that keep the car moving, with noise mixed in.
	task automatic test_random_traffic(input int count, input int gap_pct, input int stall);
		logic [3:0]  act;
		logic [2:0]  fl;
		logic [3:0]  mk;
		logic [31:0] tm;
		int          roll;
		src_gap_pct = gap_pct;
		stall_pct = stall;
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(99);
			act = esc_pkg::OP_RUN;
			fl = 3'($urandom_range(7));
			mk = 4'($urandom_range(15));
			tm = $urandom;
			if ((car_mode == esc_pkg::ST_UP || car_mode == esc_pkg::ST_DOWN) &&
					!sensor_waiting && roll < 40) begin
				act = esc_pkg::OP_SENSOR;
				if (roll < 36)
					fl = 3'((car_mode == esc_pkg::ST_UP) ? car_at + 1 : car_at - 1);
			end else if (door_timer_on && roll < 25) begin
				act = esc_pkg::OP_DOOR_DONE;
			end else if (estop_on && roll < 30) begin
				act = esc_pkg::OP_ECLEAR;
			end else if (car_mode == esc_pkg::ST_INDEP && roll < 12) begin
				act = esc_pkg::OP_INDEP_OFF;
			end else begin
				roll = $urandom_range(99);
				if (roll < 14) begin
					act = esc_pkg::OP_CABIN;
					if (roll >= 2) fl = 3'($urandom_range(esc_pkg::FLOORS, 1));
				end else if (roll < 22) act = esc_pkg::OP_HALL;
				else if (roll < 27) act = esc_pkg::OP_SENSOR;
				else if (roll < 30) act = esc_pkg::OP_DOOR_DONE;
				else if (roll < 32) act = esc_pkg::OP_ESTOP;
				else if (roll < 34) act = esc_pkg::OP_INDEP_ON;
				else if (roll < 35) act = esc_pkg::OP_INDEP_OFF;
				else if (roll < 37) act = 4'($urandom_range(15, esc_pkg::OP_NOP));
				else if (roll < 38) act = esc_pkg::OP_ECLEAR;
			end
			if (act == esc_pkg::OP_RUN) begin
				// Now and then the clock jumps anywhere, wrap included.
				if ($urandom_range(49) == 0) clock_ms = $urandom;
				else clock_ms += $urandom_range(2 * cfg_ivl);
				tm = clock_ms;
			end
			send_event(act, fl, mk, tm);
		end
	endtask

	always @(posedge clk) begin : status_check
		esc_pkg::result_t got;
		esc_pkg::result_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (expected_status.size() == 0) begin
				$display("%0t: status transfer with none expected, actual %h", $time, got);
				err_count++;
			end else begin
				want = expected_status.pop_front();
				check_field("fsm_state", want.fsm_state, got.fsm_state);
				check_field("packet_state", want.packet_state, got.packet_state);
				check_field("car_floor", want.car_floor, got.car_floor);
				check_field("goal_floor", want.goal_floor, got.goal_floor);
				check_field("travel_dir", want.travel_dir, got.travel_dir);
				check_field("pending_mask", want.pending_mask, got.pending_mask);
				check_field("door_flag", want.door_flag, got.door_flag);
				check_field("motor_duty", want.motor_duty, got.motor_duty);
				check_field("start_door_timer", want.start_door_timer, got.start_door_timer);
			end
		end
		m_axis_tready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_events();
		test_ramp_corners();
		clock_ms = 32'hFFFF_FFF0;
		load_settings(100, 100, 0, 1, 1);
		test_random_traffic(650, 6, 83);
		load_settings(0, 0, 100, 100, 65535);
		test_random_traffic(650, 83, 6);
		load_settings($urandom_range(100), $urandom_range(100), $urandom_range(100),
			$urandom_range(100, 1), $urandom_range(200, 1));
		test_random_traffic(650, 0, 0);
		drain_results();
		if (err_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
